[design/pakl_pkg.sv]
// Shared codes and field widths for the packed automaton key lookup.
`default_nettype none
package pakl_pkg;

	localparam int ADDR_FIELD_W = 16;
	localparam int SYM_W        = 8;
	localparam int ENTRY_IDX_W  = 32;
	localparam int START_W      = 16;
	localparam int CFG_DATA_W   = 16;
	localparam int CFG_IDX_W    = 1;

	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;
	typedef logic [SYM_W-1:0]     sym_t;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_KEY   = 1'b1;

	localparam cfg_idx_t CFG_START_STATE  = 1'b0;
	localparam cfg_idx_t CFG_FINAL_SYMBOL = 1'b1;

	localparam sym_t FINAL_SYMBOL_RESET = 8'hFF;

endpackage
`default_nettype wire

[design/packed_automaton_key_lookup.sv]
// Top level of the packed automaton key lookup: walk control around one table memory.
// A write word is taken while idle; a key byte that probes the table also passes the
// read state. The last byte of a key adds the final-symbol probe and the final state,
// which waits for a free output register. Each probe is one read of the table memory.
// Reset clears the walk, the registers (start state 0, final symbol 255) and the output;
// the table contents are undefined until written and no clearing pass runs.
`default_nettype none
module packed_automaton_key_lookup #(
	parameter int TABLE_DEPTH = 65536,
	parameter int INDEX_WIDTH = 32
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               in_valid,
	output logic                                    in_ready,
	input  wire logic                               operation,
	input  wire logic [pakl_pkg::ADDR_FIELD_W-1:0]  entry_address,
	input  wire logic [pakl_pkg::SYM_W-1:0]         entry_symbol,
	input  wire logic [pakl_pkg::ENTRY_IDX_W-1:0]   entry_index,
	input  wire logic [pakl_pkg::SYM_W-1:0]         key_byte,
	input  wire logic                               key_last,
	output logic                                    out_valid,
	input  wire logic                               out_ready,
	output logic                                    found,
	output logic      [pakl_pkg::ENTRY_IDX_W-1:0]   data_offset,
	input  wire logic                               cfg_valid,
	output logic                                    cfg_ready,
	input  wire logic [pakl_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [pakl_pkg::CFG_DATA_W-1:0]    cfg_data
);

	import pakl_pkg::*;

	localparam int AW     = $clog2(TABLE_DEPTH);
	localparam int DW     = SYM_W + INDEX_WIDTH;
	localparam int CMP_W  = (INDEX_WIDTH + 1 > AW + 1) ? INDEX_WIDTH + 1 : AW + 1;
	localparam int WCMP_W = (ADDR_FIELD_W + 1 > AW + 1) ? ADDR_FIELD_W + 1 : AW + 1;

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_READ  = 3'b010,
		ST_FINAL = 3'b100
	} state_t;

	state_t state_q;

	logic [START_W-1:0]     start_state_q;
	sym_t                   final_symbol_q;
	logic [INDEX_WIDTH-1:0] walk_state_q;
	logic                   walk_failed_q;
	logic                   in_key_q;
	sym_t                   sym_q;
	logic                   last_q;
	logic                   probe_ok_q;
	logic                   out_valid_q;
	logic                   found_q;
	logic [ENTRY_IDX_W-1:0] data_offset_q;

	logic                   in_acc;
	logic                   key_acc;
	logic [INDEX_WIDTH-1:0] key_base;
	logic                   key_fail;
	logic                   key_step;
	logic                   final_ok;
	logic [DW-1:0]          rd_data;
	sym_t                   rd_sym;
	logic [INDEX_WIDTH-1:0] rd_idx;
	logic                   step_match;
	logic [INDEX_WIDTH-1:0] probe_base;
	sym_t                   probe_sym;
	logic [CMP_W-1:0]       probe_sum;
	logic                   probe_in;
	logic                   rd_en;
	logic [WCMP_W-1:0]      wr_wide;
	logic                   wr_en;
	logic                   out_free;
	logic                   final_found;

	assign in_ready  = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign in_acc    = in_valid && in_ready;
	assign key_acc   = in_acc && (operation == OP_KEY);

	// The first byte of a key starts from the configured start state.
	assign key_base = in_key_q ? walk_state_q : INDEX_WIDTH'(start_state_q);
	assign key_fail = in_key_q ? walk_failed_q : (start_state_q == '0);
	assign key_step = (key_byte != '0) && !key_fail;
	assign final_ok = (final_symbol_q != '0);

	assign rd_sym     = rd_data[DW-1:INDEX_WIDTH];
	assign rd_idx     = rd_data[INDEX_WIDTH-1:0];
	assign step_match = (rd_sym == sym_q);

	always_comb begin
		if (state_q == ST_READ) begin
			probe_base = rd_idx;
			probe_sym  = final_symbol_q;
		end else begin
			probe_base = key_base;
			probe_sym  = key_step ? key_byte : final_symbol_q;
		end
	end

	assign probe_sum = CMP_W'(probe_base) + CMP_W'(probe_sym);
	assign probe_in  = (probe_sum < CMP_W'(TABLE_DEPTH));

	always_comb begin
		case (state_q)
			ST_IDLE: rd_en = key_acc && probe_in &&
				(key_step || (key_last && !key_fail && final_ok));
			ST_READ: rd_en = last_q && step_match && final_ok && probe_in;
			default: rd_en = 1'b0;
		endcase
	end

	assign wr_wide = WCMP_W'(entry_address);
	assign wr_en   = in_acc && (operation == OP_WRITE) && (wr_wide < WCMP_W'(TABLE_DEPTH));

	assign out_free    = !out_valid_q || out_ready;
	assign final_found = probe_ok_q && (rd_sym == sym_q);

	pakl_table #(
		.DEPTH(TABLE_DEPTH),
		.AW   (AW),
		.DW   (DW)
	) u_table (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(wr_wide[AW-1:0]),
		.wr_data({entry_symbol, entry_index[INDEX_WIDTH-1:0]}),
		.rd_en  (rd_en),
		.rd_addr(probe_sum[AW-1:0]),
		.rd_data(rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_state_q  <= '0;
			final_symbol_q <= FINAL_SYMBOL_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_START_STATE:  start_state_q  <= cfg_data;
				CFG_FINAL_SYMBOL: final_symbol_q <= cfg_data[SYM_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			walk_state_q  <= '0;
			walk_failed_q <= 1'b0;
			in_key_q      <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			// The final state raises the result word itself, so it is not dropped here.
			if (out_valid_q && out_ready && state_q != ST_FINAL) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (key_acc) begin
						in_key_q     <= 1'b1;
						walk_state_q <= key_base;
						if (key_step) begin
							walk_failed_q <= !probe_in;
							if (probe_in) begin
								state_q <= ST_READ;
							end else if (key_last) begin
								state_q <= ST_FINAL;
							end
						end else begin
							// A zero byte inside a key kills the walk.
							walk_failed_q <= key_fail || (key_byte == '0 && !key_last);
							if (key_last) begin
								state_q <= ST_FINAL;
							end
						end
					end
				end
				ST_READ: begin
					if (step_match) begin
						walk_state_q <= rd_idx;
					end else begin
						walk_failed_q <= 1'b1;
					end
					state_q <= last_q ? ST_FINAL : ST_IDLE;
				end
				ST_FINAL: begin
					if (out_free) begin
						out_valid_q   <= 1'b1;
						in_key_q      <= 1'b0;
						walk_failed_q <= 1'b0;
						walk_state_q  <= '0;
						state_q       <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (key_acc) begin
					last_q <= key_last;
					if (key_step) begin
						sym_q      <= key_byte;
						probe_ok_q <= 1'b0;
					end else begin
						sym_q      <= final_symbol_q;
						probe_ok_q <= !key_fail && final_ok && probe_in;
					end
				end
			end
			ST_READ: begin
				sym_q      <= final_symbol_q;
				probe_ok_q <= step_match && final_ok && probe_in;
			end
			ST_FINAL: begin
				if (out_free) begin
					found_q       <= final_found;
					data_offset_q <= final_found ? ENTRY_IDX_W'(rd_idx) : '0;
				end
			end
			default: ;
		endcase
	end

	assign out_valid   = out_valid_q;
	assign found       = found_q;
	assign data_offset = data_offset_q;

	a_no_rw_collision: assert property (@(posedge clk) disable iff (!arst_n)
		!(wr_en && rd_en))
		else $error("table read and write in the same cycle");

	a_walk_cleared_between_keys: assert property (@(posedge clk) disable iff (!arst_n)
		!in_key_q |-> (!walk_failed_q && walk_state_q == '0))
		else $error("walk state not cleared outside a key");

	a_result_from_final: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == ST_FINAL))
		else $error("result word raised outside the final probe");

	a_miss_has_zero_offset: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !found) |-> (data_offset == '0))
		else $error("nonzero data offset on a miss");

endmodule
`default_nettype wire

[design/pakl_table.sv]
// Single-port-write, single-port-read table with registered read data.
`default_nettype none
module pakl_table #(
	parameter int DEPTH = 65536,
	parameter int AW    = 16,
	parameter int DW    = 40
) (
	input  wire logic          clk,
	input  wire logic          wr_en,
	input  wire logic [AW-1:0] wr_addr,
	input  wire logic [DW-1:0] wr_data,
	input  wire logic          rd_en,
	input  wire logic [AW-1:0] rd_addr,
	output logic      [DW-1:0] rd_data
);

	logic [DW-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule
`default_nettype wire

[verif/tb_packed_automaton_key_lookup.sv]
// Self-checking testbench for the packed automaton key lookup: table loads, key walks, config.
module tb_packed_automaton_key_lookup;
	import pakl_pkg::*;

	localparam int TABLE_CELLS   = 65536;
	localparam int IDX_W         = 32;
	localparam int STUCK_LIMIT   = 1000;
	localparam int SETTLE_CYCLES = 12;
	localparam int HOLD_CYCLES   = 300;
	localparam int RANDOM_WORDS  = 1250;
	localparam int PHASES        = 5;
	localparam int MAX_REPORTS   = 40;
	localparam int DICT_SIZE     = 12;
	localparam int KEY_MAX       = 12;

	typedef logic [IDX_W-1:0] index_t;
	typedef struct packed {
		logic   hit;
		index_t offset;
	} lookup_t;

	localparam logic [IDX_W:0] TABLE_END = (IDX_W + 1)'(TABLE_CELLS);

	logic                    clk = 1'b0;
	logic                    arst_n;
	logic                    in_valid;
	logic                    in_ready;
	logic                    operation;
	logic [ADDR_FIELD_W-1:0] entry_address;
	sym_t                    entry_symbol;
	logic [ENTRY_IDX_W-1:0]  entry_index;
	sym_t                    key_byte;
	logic                    key_last;
	logic                    out_valid;
	logic                    out_ready;
	logic                    found;
	logic [ENTRY_IDX_W-1:0]  data_offset;
	logic                    cfg_valid;
	logic                    cfg_ready;
	cfg_idx_t                cfg_index;
	logic [CFG_DATA_W-1:0]   cfg_data;

	// Mirror of the tables, the registers and the walk in progress.
	bit [SYM_W-1:0]  cell_symbol [TABLE_CELLS];
	bit [IDX_W-1:0]  cell_index  [TABLE_CELLS];
	bit              cell_loaded [TABLE_CELLS];
	logic [START_W-1:0] start_base    = '0;
	sym_t               accept_symbol = FINAL_SYMBOL_RESET;
	index_t             walk_node     = '0;
	bit                 walk_dead     = 1'b0;
	bit                 walk_busy     = 1'b0;
	lookup_t            lookup_answers [$];

	// Keys planted in the tables for the current start state.
	sym_t key_buf [KEY_MAX];
	int   key_len;
	sym_t dict_keys [DICT_SIZE][KEY_MAX];
	int   dict_lens [DICT_SIZE];
	int   dict_count = 0;

	bit quiet_in     = 1'b0;
	bit quiet_out    = 1'b0;
	int hold_asked   = 0;
	int holds_done   = 0;
	int errors       = 0;
	int words_sent   = 0;
	int writes_sent  = 0;
	int bytes_sent   = 0;
	int results_seen = 0;
	int found_count  = 0;
	int settings     = 0;
	int stuck_cycles = 0;

	packed_automaton_key_lookup #(
		.TABLE_DEPTH(TABLE_CELLS),
		.INDEX_WIDTH(IDX_W)
	) u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.operation    (operation),
		.entry_address(entry_address),
		.entry_symbol (entry_symbol),
		.entry_index  (entry_index),
		.key_byte     (key_byte),
		.key_last     (key_last),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.found        (found),
		.data_offset  (data_offset),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always #4 clk = ~clk;

	function automatic bit probe_cell(index_t node, sym_t sym, output logic [15:0] hit_addr);
		logic [IDX_W:0] addr;
		addr = {1'b0, node} + (IDX_W + 1)'(sym);
		hit_addr = addr[15:0];
		if (addr >= TABLE_END)
			return 1'b0;
		return cell_symbol[addr[15:0]] == sym;
	endfunction

	// Applies one accepted word to the mirror; a last key byte queues the lookup answer.
	function automatic void advance_walk(logic op, logic [15:0] addr, sym_t sym, index_t idx,
			sym_t kbyte, logic klast);
		logic [15:0] hit_addr;
		lookup_t     answer;
		logic        hit;
		if (op == OP_WRITE) begin
			cell_symbol[addr] = sym;
			cell_index[addr]  = idx;
			cell_loaded[addr] = 1'b1;
			return;
		end
		if (!walk_busy) begin
			walk_node = index_t'(start_base);
			walk_dead = (start_base == 0);
			walk_busy = 1'b1;
		end
		if (kbyte != 0) begin
			if (!walk_dead) begin
				if (probe_cell(walk_node, kbyte, hit_addr))
					walk_node = cell_index[hit_addr];
				else
					walk_dead = 1'b1;
			end
		end else if (!klast) begin
			walk_dead = 1'b1;
		end
		if (!klast)
			return;
		hit = 1'b0;
		if (!walk_dead && accept_symbol != 0)
			hit = probe_cell(walk_node, accept_symbol, hit_addr);
		answer.hit    = hit;
		answer.offset = hit ? index_t'(cell_index[hit_addr]) : '0;
		lookup_answers.insert(lookup_answers.size(), answer);
		walk_busy = 1'b0;
		walk_dead = 1'b0;
		walk_node = '0;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] want, logic [31:0] got);
		if (errors < MAX_REPORTS)
			$display("[%0t] mismatch on %s: expected %0h, got %0h", $realtime, what, want, got);
		errors++;
	endtask

	// A word stays offered until accepted; valid is only lowered when a gap is drawn.
	task automatic send_word(logic op, logic [15:0] addr, sym_t sym, index_t idx, sym_t kbyte,
			logic klast);
		int gap;
		gap = quiet_in ? 0 : $urandom_range(0, 8);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid      <= 1'b1;
		operation     <= op;
		entry_address <= addr;
		entry_symbol  <= sym;
		entry_index   <= idx;
		key_byte      <= kbyte;
		key_last      <= klast;
		do @(posedge clk); while (!in_ready);
		advance_walk(op, addr, sym, idx, kbyte, klast);
		words_sent++;
		if (op == OP_WRITE)
			writes_sent++;
		else
			bytes_sent++;
	endtask

	task automatic write_cell(logic [15:0] addr, sym_t sym, index_t idx);
		send_word(OP_WRITE, addr, sym, idx, 8'($urandom), 1'($urandom_range(0, 1)));
	endtask

	// Loads a cell that a coming probe would otherwise read before it was ever written.
	task automatic load_if_blank(index_t node, sym_t sym);
		logic [IDX_W:0] addr;
		addr = {1'b0, node} + (IDX_W + 1)'(sym);
		if (addr < TABLE_END && !cell_loaded[addr[15:0]])
			write_cell(addr[15:0], 8'($urandom),
				$urandom_range(0, 1) ? 32'($urandom) : 32'($urandom_range(0, TABLE_CELLS - 1)));
	endtask

	// Every cell that this byte will probe is loaded before the byte goes out.
	task automatic send_key_byte(sym_t kbyte, logic klast);
		index_t      node;
		bit          dead;
		logic [15:0] hit_addr;
		node = walk_busy ? walk_node : index_t'(start_base);
		dead = walk_busy ? walk_dead : (start_base == 0);
		if (kbyte != 0 && !dead) begin
			load_if_blank(node, kbyte);
			if (probe_cell(node, kbyte, hit_addr))
				node = cell_index[hit_addr];
			else
				dead = 1'b1;
		end
		if (klast && !dead && accept_symbol != 0)
			load_if_blank(node, accept_symbol);
		send_word(OP_KEY, 16'($urandom), 8'($urandom), 32'($urandom), kbyte, klast);
	endtask

	// Sends key_buf; with mixed set, table writes may land between the bytes of the key.
	task automatic send_key(bit mixed);
		logic [15:0] hot;
		for (int i = 0; i < key_len; i++) begin
			if (mixed && i > 0 && $urandom_range(0, 19) == 0) begin
				hot = 16'(start_base + key_buf[0]);
				if ($urandom_range(0, 1))
					write_cell(hot, key_buf[0], index_t'($urandom_range(1, 65000)));
				else
					write_cell(16'($urandom), 8'($urandom), 32'($urandom));
			end
			send_key_byte(key_buf[i], i == key_len - 1);
		end
	endtask

	// Pauses the sender until every lookup is answered, then lets the block settle.
	task automatic drain_lookups();
		in_valid <= 1'b0;
		while (lookup_answers.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic configure(logic [START_W-1:0] start, sym_t fsym);
		cfg_valid <= 1'b1;
		cfg_index <= CFG_START_STATE;
		cfg_data  <= start;
		do @(posedge clk); while (!cfg_ready);
		start_base = start;
		cfg_index <= CFG_FINAL_SYMBOL;
		cfg_data  <= {8'($urandom), fsym};
		do @(posedge clk); while (!cfg_ready);
		accept_symbol = fsym;
		cfg_valid <= 1'b0;
		settings++;
	endtask

	// Writes whatever cells are missing for key_buf to walk from the start state and accept.
	task automatic plant_key(int len);
		index_t         node;
		logic [IDX_W:0] addr;
		node = index_t'(start_base);
		for (int i = 0; i < len; i++) begin
			addr = {1'b0, node} + (IDX_W + 1)'(key_buf[i]);
			if (addr >= TABLE_END || key_buf[i] == 0)
				return;
			if (cell_symbol[addr[15:0]] != key_buf[i])
				write_cell(addr[15:0], key_buf[i], index_t'($urandom_range(1, TABLE_CELLS - 257)));
			node = cell_index[addr[15:0]];
		end
		addr = {1'b0, node} + (IDX_W + 1)'(accept_symbol);
		if (addr < TABLE_END)
			write_cell(addr[15:0], accept_symbol, 32'($urandom));
	endtask

	task automatic new_dict_key();
		int slot;
		int share;
		key_len = $urandom_range(1, 6);
		share = 0;
		if (dict_count > 0 && $urandom_range(0, 1)) begin
			slot  = $urandom_range(0, dict_count - 1);
			share = $urandom_range(1, dict_lens[slot]);
			for (int i = 0; i < share && i < key_len; i++)
				key_buf[i] = dict_keys[slot][i];
		end
		for (int i = share; i < key_len; i++)
			key_buf[i] = 8'($urandom_range(1, 255));
		plant_key(key_len);
		if (dict_count < DICT_SIZE) begin
			slot = dict_count;
			dict_count++;
		end else begin
			slot = $urandom_range(0, DICT_SIZE - 1);
		end
		for (int i = 0; i < key_len; i++)
			dict_keys[slot][i] = key_buf[i];
		dict_lens[slot] = key_len;
	endtask

	task automatic load_dict_key();
		int slot;
		slot    = $urandom_range(0, dict_count - 1);
		key_len = dict_lens[slot];
		for (int i = 0; i < key_len; i++)
			key_buf[i] = dict_keys[slot][i];
	endtask

	// Near misses: a changed byte, a dropped or added tail byte, or a zero byte slipped in.
	task automatic mutate_key();
		int p;
		case ($urandom_range(0, 3))
			0: key_buf[$urandom_range(0, key_len - 1)] = 8'($urandom_range(1, 255));
			1: if (key_len > 1) key_len--;
			2: begin
				key_buf[key_len] = 8'($urandom_range(1, 255));
				key_len++;
			end
			default: begin
				p = $urandom_range(0, key_len);
				for (int j = key_len; j > p; j--)
					key_buf[j] = key_buf[j - 1];
				key_buf[p] = 8'h00;
				key_len++;
			end
		endcase
	endtask

	// Reset leaves the start state at zero, so nothing can be found.
	task automatic test_reset_defaults();
		send_key_byte(8'd5, 1'b1);
		send_key_byte(8'h00, 1'b1);
		drain_lookups();
	endtask

	task automatic test_field_extremes();
		configure(16'd1, 8'hFF);
		write_cell(16'd256, 8'hFF, 32'hFFFF_FFFF);
		write_cell(16'd2, 8'h01, 32'h0000_0000);
		write_cell(16'd255, 8'hFF, 32'h0000_0000);
		write_cell(16'd3, 8'h00, 32'h0000_0001);
		send_key_byte(8'h00, 1'b1);
		send_key_byte(8'h01, 1'b1);
		send_key_byte(8'hFF, 1'b1);
		send_key_byte(8'h02, 1'b1);
		send_key_byte(8'h01, 1'b0);
		send_key_byte(8'h00, 1'b0);
		send_key_byte(8'h01, 1'b1);
		send_key_byte(8'h01, 1'b0);
		send_key_byte(8'h00, 1'b1);
		drain_lookups();
		// Every probe from the top cell runs past the end of the table.
		configure(16'hFFFF, 8'h01);
		send_key_byte(8'h00, 1'b1);
		send_key_byte(8'h01, 1'b1);
		drain_lookups();
		configure(16'hFFFE, 8'h01);
		write_cell(16'hFFFF, 8'h01, 32'h1234_5678);
		send_key_byte(8'h00, 1'b1);
		drain_lookups();
	endtask

	// The start state is taken at the first byte, so a rewrite mid-key applies to the next key.
	task automatic test_start_sampling();
		configure(16'd1000, 8'd7);
		key_buf[0] = 8'd3;
		key_buf[1] = 8'd9;
		key_len    = 2;
		plant_key(2);
		send_key_byte(key_buf[0], 1'b0);
		drain_lookups();
		configure(16'd5000, 8'd7);
		send_key_byte(key_buf[1], 1'b1);
		send_key(1'b0);
		drain_lookups();
	endtask

	task automatic test_result_backpressure();
		configure(16'($urandom_range(1, 60000)), 8'($urandom_range(1, 255)));
		dict_count = 0;
		repeat (4) new_dict_key();
		quiet_in = 1'b1;
		hold_asked++;
		repeat (40) begin
			load_dict_key();
			send_key(1'b0);
		end
		quiet_in = 1'b0;
		drain_lookups();
	endtask

	task automatic test_random_traffic();
		int target;
		int pick;
		logic [START_W-1:0] start;
		sym_t fsym;
		for (int phase = 0; phase < PHASES; phase++) begin
			drain_lookups();
			case (phase)
				0: begin
					start = 16'($urandom_range(1, 60000));
					fsym  = 8'hFF;
				end
				1: begin
					start = 16'd1;
					fsym  = 8'h01;
				end
				2: begin
					start = 16'hFF00;
					fsym  = 8'($urandom_range(1, 255));
				end
				default: begin
					start = 16'($urandom_range(1, 65535));
					fsym  = 8'($urandom_range(1, 255));
				end
			endcase
			configure(start, fsym);
			dict_count = 0;
			target = words_sent + RANDOM_WORDS / PHASES;
			while (words_sent < target) begin
				if ($urandom_range(0, 99) < 4) begin
					quiet_in  = $urandom_range(0, 3) == 0;
					quiet_out = $urandom_range(0, 3) == 0;
				end
				pick = $urandom_range(0, 99);
				if (pick < 15 || dict_count == 0) begin
					new_dict_key();
					send_key(1'b1);
				end else if (pick < 65) begin
					load_dict_key();
					send_key(1'b1);
				end else if (pick < 77) begin
					load_dict_key();
					mutate_key();
					send_key(1'b1);
				end else if (pick < 82) begin
					send_key_byte(8'h00, 1'b1);
				end else if (pick < 92) begin
					write_cell(16'($urandom), 8'($urandom), 32'($urandom));
				end else if (pick < 98) begin
					key_len = $urandom_range(1, 6);
					for (int i = 0; i < key_len; i++)
						key_buf[i] = 8'($urandom);
					send_key(1'b1);
				end else begin
					drain_lookups();
				end
			end
		end
		quiet_in  = 1'b0;
		quiet_out = 1'b0;
	endtask

	initial begin : result_sink
		int stall;
		out_ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			// A requested hold keeps the output blocked long enough for the input to back up.
			if (holds_done < hold_asked) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				holds_done++;
			end
			stall = quiet_out ? 0 : $urandom_range(0, 8);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
		end
	end

	always @(posedge clk) begin : result_check
		lookup_t want;
		if (arst_n && out_valid && out_ready) begin
			if (lookup_answers.size() == 0) begin
				report_mismatch("result with no lookup pending", 32'd0, data_offset);
			end else begin
				want = lookup_answers.pop_front();
				results_seen++;
				if (want.hit)
					found_count++;
				if (found !== want.hit)
					report_mismatch("found", 32'(want.hit), 32'(found));
				if (data_offset !== want.offset)
					report_mismatch("data_offset", want.offset, data_offset);
			end
		end
	end

	always @(posedge clk) begin : watchdog
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)
				|| !arst_n) begin
			stuck_cycles = 0;
		end else begin
			stuck_cycles++;
			if (stuck_cycles >= STUCK_LIMIT) begin
				$display("Timeout: %0d cycles without an accepted word", STUCK_LIMIT);
				$display("CHECK FAILED");
				$finish;
			end
		end
	end

	initial begin
		arst_n        <= 1'b0;
		in_valid      <= 1'b0;
		operation     <= OP_WRITE;
		entry_address <= '0;
		entry_symbol  <= '0;
		entry_index   <= '0;
		key_byte      <= '0;
		key_last      <= 1'b0;
		cfg_valid     <= 1'b0;
		cfg_index     <= CFG_START_STATE;
		cfg_data      <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_field_extremes();
		test_start_sampling();
		test_result_backpressure();
		test_random_traffic();
		drain_lookups();
		$display("Sent %0d words (%0d table writes, %0d key bytes) under %0d register settings.",
			words_sent, writes_sent, bytes_sent, settings);
		$display("Checked %0d lookups, %0d of them found, with %0d long result stall(s).",
			results_seen, found_count, holds_done);
		if (errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
